/* design/co2seq_pkg.sv */
`timescale 1ns / 1ps
package co2seq_pkg;

    localparam int REPLY_BYTES_DEF        = 49;
    localparam int SENSOR_STATE_BYTES_DEF = 23;

    localparam logic [15:0] PRESSURE_RST   = 16'd10124;
    localparam logic [31:0] CALIB_PER_RST  = 32'd691200000;
    localparam logic [7:0]  ABC_RST        = 8'd112;
    localparam logic [7:0]  ABC_RF_RST     = 8'd114;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [7:0] ADDR_BYTE    = 8'hFE;
    localparam logic [7:0] CMD_WRITE    = 8'h41;
    localparam logic [7:0] CMD_READ     = 8'h44;
    localparam logic [7:0] CMD_SEQ      = 8'h20;
    localparam logic [7:0] REG_HI       = 8'h00;
    localparam logic [7:0] REG_LO       = 8'h80;
    localparam logic [7:0] INIT_LEN     = 8'h01;
    localparam logic [7:0] INIT_CMD     = 8'h10;
    localparam logic [7:0] INIT_CRC_LO  = 8'h28;
    localparam logic [7:0] INIT_CRC_HI  = 8'h7E;
    localparam logic [7:0] STAT0_MASK   = 8'hDD;
    localparam logic [7:0] STAT1_MASK   = 8'hF7;
    localparam logic [7:0] STAT0_CALIB  = 8'h08;
    localparam logic [15:0] CONC_MAX    = 16'd10000;

    // byte positions in the long reply
    localparam int IDX_CONC_HI = 29;
    localparam int IDX_CONC_LO = 30;
    localparam int IDX_STAT1   = 41;
    localparam int IDX_STAT0   = 42;
    localparam int IDX_STATE   = 4;
    localparam int ACK_BYTES   = 4;

    localparam logic [31:0] T_INIT_CHARGE = 32'd60000;
    localparam logic [31:0] T_CHARGE      = 32'd5000;
    localparam logic [31:0] T_BOOT_TO     = 32'd300;
    localparam logic [31:0] T_BOOT_WAIT   = 32'd140;
    localparam logic [31:0] T_POLL        = 32'd10;
    localparam logic [31:0] T_ACK_TO      = 32'd80;
    localparam logic [31:0] T_MEAS_TO_CAL = 32'd1000;
    localparam logic [31:0] T_MEAS_TO     = 32'd250;
    localparam logic [31:0] T_MEAS_WAIT   = 32'd50;
    localparam logic [31:0] T_REPLY_TO    = 32'd100;
    localparam logic [31:0] T_RETRY       = 32'd100;
    localparam logic [31:0] T_ERR_WAIT    = 32'd500;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_MEAS  = 2'd2;
    localparam logic [1:0] KIND_CALIB = 2'd3;

    localparam logic [2:0] CFG_PRESSURE = 3'd0;
    localparam logic [2:0] CFG_PERIOD   = 3'd1;
    localparam logic [2:0] CFG_CAL_PER  = 3'd2;
    localparam logic [2:0] CFG_ABC      = 3'd3;
    localparam logic [2:0] CFG_ABC_RF   = 3'd4;

    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_MEAS = 2'd1;
    localparam logic [1:0] EV_ERR  = 2'd2;

    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_BOOT_TO    = 4'd1;
    localparam logic [3:0] ERR_ACK_ADDR   = 4'd2;
    localparam logic [3:0] ERR_ACK_CMD    = 4'd3;
    localparam logic [3:0] ERR_ACK_CRC    = 4'd4;
    localparam logic [3:0] ERR_ACK_TO     = 4'd5;
    localparam logic [3:0] ERR_MEAS_TO    = 4'd6;
    localparam logic [3:0] ERR_REP_ADDR   = 4'd7;
    localparam logic [3:0] ERR_REP_CMD    = 4'd8;
    localparam logic [3:0] ERR_REP_CRC    = 4'd9;
    localparam logic [3:0] ERR_REP_STAT0  = 4'd10;
    localparam logic [3:0] ERR_REP_STAT1  = 4'd11;
    localparam logic [3:0] ERR_REP_TO     = 4'd12;

    typedef enum logic [2:0] {
        PH_INIT, PH_READY, PH_PRECHARGE, PH_CHARGE,
        PH_BOOT, PH_BOOT_READ, PH_MEASURE, PH_MEASURE_READ
    } phase_t;

    typedef enum logic [1:0] {
        FR_INIT, FR_SEQ, FR_READ
    } frame_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_NOW, ST_INTERVAL, ST_WAKE, ST_RUN, ST_RESULT, ST_REPORT, ST_SEND
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic tick_now;
        logic serve_interval;
        logic run;
        logic request;
        logic send;
        logic report;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic run_due;
        logic is_frame;
        logic last_byte;
    } status_t;

    function automatic logic [15:0] crc_step(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic reached(input logic [31:0] now, input logic [31:0] t);
        logic [31:0] d;
        d = now - t;
        return ~d[31];
    endfunction

endpackage

/* design/co2seq_ctrl.sv */
`timescale 1ns / 1ps
module co2seq_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic [1:0]            s_tuser,
    output logic                  s_tready,
    input  co2seq_pkg::status_t   sts,
    output co2seq_pkg::cmd_t      cmd
);

    co2seq_pkg::ctrl_state_t state_reg, state_next;
    logic req_pend_reg, req_pend_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= co2seq_pkg::ST_IDLE;
            req_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            req_pend_reg <= req_pend_next;
        end
    end

    // next state
    always_comb
    begin
        state_next    = state_reg;
        req_pend_next = req_pend_reg;
        case (state_reg)
            co2seq_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (s_tuser)
                        co2seq_pkg::KIND_TICK: state_next = co2seq_pkg::ST_NOW;
                        co2seq_pkg::KIND_BYTE: state_next = co2seq_pkg::ST_IDLE;
                        default:
                        begin
                            state_next    = co2seq_pkg::ST_REPORT;
                            req_pend_next = 1'b1;
                        end
                    endcase
                end
            end
            co2seq_pkg::ST_NOW:      state_next = co2seq_pkg::ST_INTERVAL;
            co2seq_pkg::ST_INTERVAL: state_next = co2seq_pkg::ST_WAKE;
            co2seq_pkg::ST_WAKE:
                state_next = sts.run_due ? co2seq_pkg::ST_RUN : co2seq_pkg::ST_IDLE;
            co2seq_pkg::ST_RUN:      state_next = co2seq_pkg::ST_RESULT;
            co2seq_pkg::ST_RESULT:
                state_next = sts.is_frame ? co2seq_pkg::ST_SEND : co2seq_pkg::ST_REPORT;
            co2seq_pkg::ST_REPORT:
            begin
                if (sts.out_free)
                begin
                    state_next    = co2seq_pkg::ST_IDLE;
                    req_pend_next = 1'b0;
                end
            end
            co2seq_pkg::ST_SEND:
            begin
                if (sts.out_free && sts.last_byte)
                begin
                    state_next = co2seq_pkg::ST_IDLE;
                end
            end
            default: state_next = co2seq_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready           = (state_reg == co2seq_pkg::ST_IDLE);
        cmd                = '0;
        cmd.accept         = s_tready && s_tvalid;
        cmd.tick_now       = (state_reg == co2seq_pkg::ST_NOW);
        cmd.serve_interval = (state_reg == co2seq_pkg::ST_INTERVAL);
        cmd.run            = (state_reg == co2seq_pkg::ST_RUN);
        cmd.request        = (state_reg == co2seq_pkg::ST_REPORT) && sts.out_free
                             && req_pend_reg;
        cmd.report         = (state_reg == co2seq_pkg::ST_REPORT) && sts.out_free
                             && !req_pend_reg;
        cmd.send           = (state_reg == co2seq_pkg::ST_SEND) && sts.out_free;
    end

endmodule

/* design/co2seq_dp.sv */
`timescale 1ns / 1ps
module co2seq_dp
#(
    parameter int REPLY_BYTES        = co2seq_pkg::REPLY_BYTES_DEF,
    parameter int SENSOR_STATE_BYTES = co2seq_pkg::SENSOR_STATE_BYTES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  co2seq_pkg::cmd_t      cmd,
    output co2seq_pkg::status_t   sts,
    input  logic [1:0]            in_kind,
    input  logic [7:0]            in_byte,
    input  logic                  in_ready,
    input  logic [7:0]            in_mode,
    input  logic                  cfg_wr,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic                  m_tlast,
    output logic                  m_tuser,
    output logic [39:0]           m_tdata
);

    localparam int CW  = $clog2(REPLY_BYTES + 1);
    localparam int SW  = $clog2(SENSOR_STATE_BYTES);
    localparam int IW  = $clog2(SENSOR_STATE_BYTES + 11);
    localparam logic [IW-1:0] LEN_INIT = IW'(8);
    localparam logic [IW-1:0] LEN_SEQ  = IW'(SENSOR_STATE_BYTES + 10);
    localparam logic [IW-1:0] LEN_READ = IW'(7);

    logic [15:0] pressure_reg, pressure_next;
    logic [31:0] period_reg, period_next;
    logic [31:0] cal_per_reg, cal_per_next;
    logic [7:0]  abc_reg, abc_next;
    logic [7:0]  abc_rf_reg, abc_rf_next;
    co2seq_pkg::phase_t phase_reg, phase_next;
    logic [31:0] now_reg, now_next;
    logic [31:0] wake_reg, wake_next;
    logic [31:0] tmo_reg, tmo_next;
    logic [31:0] cal_due_reg, cal_due_next;
    logic [31:0] intv_reg, intv_next;
    logic [7:0]  mode_reg, mode_next;
    logic        cal_run_reg, cal_run_next;
    logic        first_reg, first_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [15:0] rx_crc_reg, rx_crc_next;
    logic [7:0]  b0_reg, b0_next, b1_reg, b1_next;
    logic [7:0]  st0_reg, st0_next, st1_reg, st1_next;
    logic [7:0]  chi_reg, chi_next, clo_reg, clo_next;
    logic [7:0]  pend_reg [SENSOR_STATE_BYTES];
    logic [7:0]  pend_next [SENSOR_STATE_BYTES];
    logic [7:0]  saved_reg [SENSOR_STATE_BYTES];
    logic [7:0]  saved_next [SENSOR_STATE_BYTES];
    logic [7:0]  sent_reg, sent_next;
    logic [3:0]  err_reg, err_next;
    logic [15:0] conc_reg, conc_next;
    logic        valid_reg, valid_next;
    logic        chg_reg, chg_next, sen_reg, sen_next, uart_reg, uart_next;
    logic        rdy_in_reg, rdy_in_next;
    logic [7:0]  mode_in_reg, mode_in_next;
    logic [1:0]  kind_in_reg, kind_in_next;
    co2seq_pkg::frame_t frame_reg, frame_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [15:0] tx_crc_reg, tx_crc_next;
    logic [1:0]  res_ev_reg, res_ev_next;
    logic        res_frame_reg, res_frame_next;

    logic        ov_reg, ov_next, okind_reg, okind_next, olast_reg, olast_next;
    logic [7:0]  obyte_reg, obyte_next;
    logic [1:0]  oev_reg, oev_next;
    logic        oacc_reg, oacc_next;
    logic        ochg_reg, ochg_next, osen_reg, osen_next, ouart_reg, ouart_next;
    logic [3:0]  oerr_reg, oerr_next;
    logic [15:0] oconc_reg, oconc_next;
    logic        oval_reg, oval_next;

    logic          out_free;
    logic          meas, acc;
    logic          fail;
    logic [3:0]    fail_code;
    logic [31:0]   cal_d;
    logic [IW-1:0] flen, off;
    logic [7:0]    tx_b;
    logic          store;
    logic [15:0]   conc_w;

    assign out_free      = !ov_reg || m_tready;
    assign sts.out_free  = out_free;
    assign sts.run_due   = (phase_reg != co2seq_pkg::PH_READY)
                           && co2seq_pkg::reached(now_reg, wake_reg);
    assign sts.is_frame  = res_frame_reg;
    assign sts.last_byte = (idx_reg == flen - IW'(1));
    assign cal_d         = now_reg - cal_due_reg;
    assign off           = idx_reg - IW'(6);
    assign conc_w        = {chi_reg, clo_reg};

    // frame length and byte select
    always_comb
    begin
        case (frame_reg)
            co2seq_pkg::FR_INIT: flen = LEN_INIT;
            co2seq_pkg::FR_SEQ:  flen = LEN_SEQ;
            default:             flen = LEN_READ;
        endcase
        tx_b = 8'h00;
        case (idx_reg)
            IW'(0): tx_b = co2seq_pkg::ADDR_BYTE;
            IW'(1): tx_b = (frame_reg == co2seq_pkg::FR_READ) ? co2seq_pkg::CMD_READ
                                                              : co2seq_pkg::CMD_WRITE;
            IW'(2): tx_b = co2seq_pkg::REG_HI;
            IW'(3): tx_b = co2seq_pkg::REG_LO;
            default:
            begin
                case (frame_reg)
                    co2seq_pkg::FR_INIT:
                    begin
                        case (idx_reg)
                            IW'(4):  tx_b = co2seq_pkg::INIT_LEN;
                            IW'(5):  tx_b = co2seq_pkg::INIT_CMD;
                            IW'(6):  tx_b = co2seq_pkg::INIT_CRC_LO;
                            default: tx_b = co2seq_pkg::INIT_CRC_HI;
                        endcase
                    end
                    co2seq_pkg::FR_SEQ:
                    begin
                        if (idx_reg == IW'(4))
                            tx_b = 8'(SENSOR_STATE_BYTES + 3);
                        else if (idx_reg == IW'(5))
                            tx_b = cal_run_reg ? mode_reg : co2seq_pkg::CMD_SEQ;
                        else if (idx_reg < IW'(SENSOR_STATE_BYTES + 6))
                            tx_b = saved_reg[off[SW-1:0]];
                        else if (idx_reg == IW'(SENSOR_STATE_BYTES + 6))
                            tx_b = pressure_reg[15:8];
                        else if (idx_reg == IW'(SENSOR_STATE_BYTES + 7))
                            tx_b = pressure_reg[7:0];
                        else if (idx_reg == IW'(SENSOR_STATE_BYTES + 8))
                            tx_b = tx_crc_reg[7:0];
                        else
                            tx_b = tx_crc_reg[15:8];
                    end
                    default:
                    begin
                        case (idx_reg)
                            IW'(4):  tx_b = 8'(REPLY_BYTES - 5);
                            IW'(5):  tx_b = tx_crc_reg[7:0];
                            default: tx_b = tx_crc_reg[15:8];
                        endcase
                    end
                endcase
            end
        endcase
    end

    always_comb
    begin
        pressure_next = pressure_reg;
        period_next   = period_reg;
        cal_per_next  = cal_per_reg;
        abc_next      = abc_reg;
        abc_rf_next   = abc_rf_reg;
        phase_next    = phase_reg;
        now_next      = now_reg;
        wake_next     = wake_reg;
        tmo_next      = tmo_reg;
        cal_due_next  = cal_due_reg;
        intv_next     = intv_reg;
        mode_next     = mode_reg;
        cal_run_next  = cal_run_reg;
        first_next    = first_reg;
        cnt_next      = cnt_reg;
        rx_crc_next   = rx_crc_reg;
        b0_next       = b0_reg;
        b1_next       = b1_reg;
        st0_next      = st0_reg;
        st1_next      = st1_reg;
        chi_next      = chi_reg;
        clo_next      = clo_reg;
        pend_next     = pend_reg;
        saved_next    = saved_reg;
        sent_next     = sent_reg;
        err_next      = err_reg;
        conc_next     = conc_reg;
        valid_next    = valid_reg;
        chg_next      = chg_reg;
        sen_next      = sen_reg;
        uart_next     = uart_reg;
        rdy_in_next   = rdy_in_reg;
        mode_in_next  = mode_in_reg;
        kind_in_next  = kind_in_reg;
        frame_next    = frame_reg;
        idx_next      = idx_reg;
        tx_crc_next   = tx_crc_reg;
        res_ev_next   = res_ev_reg;
        res_frame_next = res_frame_reg;
        meas          = 1'b0;
        fail          = 1'b0;
        fail_code     = co2seq_pkg::ERR_NONE;
        store         = 1'b0;

        // register writes
        if (cfg_wr)
        begin
            case (cfg_index)
                co2seq_pkg::CFG_PRESSURE: pressure_next = cfg_data[15:0];
                co2seq_pkg::CFG_PERIOD:
                begin
                    period_next = cfg_data;
                    if (cfg_data != 32'd0)
                    begin
                        intv_next = now_reg + cfg_data;
                        meas      = 1'b1;
                    end
                end
                co2seq_pkg::CFG_CAL_PER: cal_per_next = cfg_data;
                co2seq_pkg::CFG_ABC:     abc_next = cfg_data[7:0];
                co2seq_pkg::CFG_ABC_RF:  abc_rf_next = cfg_data[7:0];
                default: ;
            endcase
        end

        if (cmd.accept)
        begin
            rdy_in_next  = in_ready;
            mode_in_next = in_mode;
            kind_in_next = in_kind;
            if (in_kind == co2seq_pkg::KIND_BYTE)
            begin
                store = ((phase_reg == co2seq_pkg::PH_BOOT_READ)
                         && (cnt_reg < CW'(co2seq_pkg::ACK_BYTES)))
                        || ((phase_reg == co2seq_pkg::PH_MEASURE_READ)
                         && (cnt_reg < CW'(REPLY_BYTES)));
            end
        end

        // capture the reply fields as bytes arrive
        if (store)
        begin
            cnt_next    = cnt_reg + CW'(1);
            rx_crc_next = co2seq_pkg::crc_step((cnt_reg == '0) ? co2seq_pkg::CRC_INIT
                                                               : rx_crc_reg, in_byte);
            if (cnt_reg == CW'(0))                       b0_next  = in_byte;
            if (cnt_reg == CW'(1))                       b1_next  = in_byte;
            if (cnt_reg == CW'(co2seq_pkg::IDX_CONC_HI)) chi_next = in_byte;
            if (cnt_reg == CW'(co2seq_pkg::IDX_CONC_LO)) clo_next = in_byte;
            if (cnt_reg == CW'(co2seq_pkg::IDX_STAT1))   st1_next = in_byte;
            if (cnt_reg == CW'(co2seq_pkg::IDX_STAT0))   st0_next = in_byte;
            for (int i = 0; i < SENSOR_STATE_BYTES; i++)
            begin
                if (cnt_reg == CW'(i + co2seq_pkg::IDX_STATE))
                    pend_next[i] = in_byte;
            end
        end

        if (cmd.tick_now)
            now_next = now_reg + 32'd1;

        if (cmd.serve_interval && (period_reg != 32'd0)
            && co2seq_pkg::reached(now_reg, intv_reg))
        begin
            meas      = 1'b1;
            intv_next = intv_reg + period_reg;
        end

        if (cmd.request)
            meas = 1'b1;

        if (cmd.run)
        begin
            res_ev_next    = co2seq_pkg::EV_NONE;
            res_frame_next = 1'b0;
            case (phase_reg)
                co2seq_pkg::PH_INIT, co2seq_pkg::PH_PRECHARGE:
                begin
                    chg_next   = 1'b1;
                    wake_next  = now_reg + ((phase_reg == co2seq_pkg::PH_INIT)
                                 ? co2seq_pkg::T_INIT_CHARGE : co2seq_pkg::T_CHARGE);
                    phase_next = co2seq_pkg::PH_CHARGE;
                end
                co2seq_pkg::PH_CHARGE:
                begin
                    chg_next   = 1'b0;
                    sen_next   = 1'b1;
                    phase_next = co2seq_pkg::PH_BOOT;
                    tmo_next   = now_reg + co2seq_pkg::T_BOOT_TO;
                    wake_next  = now_reg + co2seq_pkg::T_BOOT_WAIT;
                end
                co2seq_pkg::PH_BOOT:
                begin
                    if (rdy_in_reg)
                    begin
                        if (co2seq_pkg::reached(now_reg, tmo_reg))
                        begin
                            fail      = 1'b1;
                            fail_code = co2seq_pkg::ERR_BOOT_TO;
                        end
                        else
                            wake_next = now_reg + co2seq_pkg::T_POLL;
                    end
                    else
                    begin
                        if (first_reg)
                        begin
                            frame_next   = co2seq_pkg::FR_SEQ;
                            cal_run_next = (cal_d != 32'd0) && !cal_d[31];
                        end
                        else
                            frame_next   = co2seq_pkg::FR_INIT;
                        res_frame_next = 1'b1;
                        idx_next       = '0;
                        tx_crc_next    = co2seq_pkg::CRC_INIT;
                        sent_next      = co2seq_pkg::CMD_WRITE;
                        uart_next      = 1'b1;
                        cnt_next       = '0;
                        phase_next     = co2seq_pkg::PH_BOOT_READ;
                        tmo_next       = now_reg + co2seq_pkg::T_ACK_TO;
                        wake_next      = now_reg + co2seq_pkg::T_POLL;
                    end
                end
                co2seq_pkg::PH_BOOT_READ:
                begin
                    if (cnt_reg >= CW'(co2seq_pkg::ACK_BYTES))
                    begin
                        uart_next = 1'b0;
                        if (b0_reg != co2seq_pkg::ADDR_BYTE)
                        begin
                            fail = 1'b1; fail_code = co2seq_pkg::ERR_ACK_ADDR;
                        end
                        else if (b1_reg != sent_reg)
                        begin
                            fail = 1'b1; fail_code = co2seq_pkg::ERR_ACK_CMD;
                        end
                        else if (rx_crc_reg != 16'd0)
                        begin
                            fail = 1'b1; fail_code = co2seq_pkg::ERR_ACK_CRC;
                        end
                        else
                        begin
                            phase_next = co2seq_pkg::PH_MEASURE;
                            tmo_next   = now_reg + (cal_run_reg ? co2seq_pkg::T_MEAS_TO_CAL
                                                                : co2seq_pkg::T_MEAS_TO);
                            wake_next  = now_reg + co2seq_pkg::T_MEAS_WAIT;
                        end
                    end
                    else if (co2seq_pkg::reached(now_reg, tmo_reg))
                    begin
                        fail = 1'b1; fail_code = co2seq_pkg::ERR_ACK_TO;
                    end
                    else
                        wake_next = now_reg + co2seq_pkg::T_POLL;
                end
                co2seq_pkg::PH_MEASURE:
                begin
                    if (!rdy_in_reg)
                    begin
                        if (co2seq_pkg::reached(now_reg, tmo_reg))
                        begin
                            fail = 1'b1; fail_code = co2seq_pkg::ERR_MEAS_TO;
                        end
                        else
                            wake_next = now_reg + co2seq_pkg::T_POLL;
                    end
                    else
                    begin
                        frame_next     = co2seq_pkg::FR_READ;
                        res_frame_next = 1'b1;
                        idx_next       = '0;
                        tx_crc_next    = co2seq_pkg::CRC_INIT;
                        sent_next      = co2seq_pkg::CMD_READ;
                        uart_next      = 1'b1;
                        cnt_next       = '0;
                        phase_next     = co2seq_pkg::PH_MEASURE_READ;
                        tmo_next       = now_reg + co2seq_pkg::T_REPLY_TO;
                        wake_next      = now_reg + co2seq_pkg::T_POLL;
                    end
                end
                co2seq_pkg::PH_MEASURE_READ:
                begin
                    if (cnt_reg >= CW'(REPLY_BYTES))
                    begin
                        uart_next = 1'b0;
                        sen_next  = 1'b0;
                        if (b0_reg != co2seq_pkg::ADDR_BYTE)
                        begin
                            fail = 1'b1; fail_code = co2seq_pkg::ERR_REP_ADDR;
                        end
                        else if (b1_reg != sent_reg)
                        begin
                            fail = 1'b1; fail_code = co2seq_pkg::ERR_REP_CMD;
                        end
                        else if (rx_crc_reg != 16'd0)
                        begin
                            fail = 1'b1; fail_code = co2seq_pkg::ERR_REP_CRC;
                        end
                        else if (((st0_reg & co2seq_pkg::STAT0_MASK) != 8'd0) && !cal_run_reg)
                        begin
                            fail = 1'b1; fail_code = co2seq_pkg::ERR_REP_STAT0;
                        end
                        else if (((st0_reg & co2seq_pkg::STAT0_MASK) != 8'd0)
                                 && (st0_reg == co2seq_pkg::STAT0_CALIB)
                                 && (mode_reg != abc_reg) && (mode_reg != abc_rf_reg))
                        begin
                            // calibration still busy: charge again
                            phase_next = co2seq_pkg::PH_CHARGE;
                            wake_next  = now_reg + co2seq_pkg::T_RETRY;
                        end
                        else if ((st1_reg & co2seq_pkg::STAT1_MASK) != 8'd0)
                        begin
                            fail = 1'b1; fail_code = co2seq_pkg::ERR_REP_STAT1;
                        end
                        else
                        begin
                            if (cal_run_reg)
                            begin
                                mode_next    = abc_reg;
                                cal_due_next = now_reg + cal_per_reg;
                            end
                            saved_next  = pend_reg;
                            first_next  = 1'b1;
                            conc_next   = conc_w;
                            valid_next  = (conc_w <= co2seq_pkg::CONC_MAX);
                            phase_next  = co2seq_pkg::PH_READY;
                            res_ev_next = co2seq_pkg::EV_MEAS;
                        end
                    end
                    else if (co2seq_pkg::reached(now_reg, tmo_reg))
                    begin
                        fail = 1'b1; fail_code = co2seq_pkg::ERR_REP_TO;
                    end
                    else
                        wake_next = now_reg + co2seq_pkg::T_POLL;
                end
                default: ;
            endcase
            if (fail)
            begin
                err_next    = fail_code;
                valid_next  = 1'b0;
                first_next  = 1'b0;
                chg_next    = 1'b0;
                sen_next    = 1'b0;
                uart_next   = 1'b0;
                phase_next  = co2seq_pkg::PH_INIT;
                wake_next   = now_reg + co2seq_pkg::T_ERR_WAIT;
                res_ev_next = co2seq_pkg::EV_ERR;
            end
        end

        if (cmd.send)
        begin
            idx_next = idx_reg + IW'(1);
            if (idx_reg < flen - IW'(2))
                tx_crc_next = co2seq_pkg::crc_step(tx_crc_reg, tx_b);
        end

        // calibration request stores its mode before acting as a measure request
        if (cmd.request && (kind_in_reg == co2seq_pkg::KIND_CALIB))
        begin
            mode_next    = mode_in_reg;
            cal_due_next = now_reg;
        end

        acc = meas && (phase_reg == co2seq_pkg::PH_READY);
        if (meas)
        begin
            if (phase_reg == co2seq_pkg::PH_READY)
            begin
                phase_next = co2seq_pkg::PH_PRECHARGE;
                wake_next  = now_reg;
            end
            else if (phase_reg == co2seq_pkg::PH_INIT)
                wake_next = now_reg;
        end
    end

    // output stage
    always_comb
    begin
        ov_next    = ov_reg && !m_tready;
        okind_next = okind_reg;
        obyte_next = obyte_reg;
        olast_next = olast_reg;
        oev_next   = oev_reg;
        oacc_next  = oacc_reg;
        ochg_next  = ochg_reg;
        osen_next  = osen_reg;
        ouart_next = ouart_reg;
        oerr_next  = oerr_reg;
        oconc_next = oconc_reg;
        oval_next  = oval_reg;
        if (cmd.send || cmd.report || cmd.request)
        begin
            ov_next    = 1'b1;
            okind_next = !cmd.send;
            obyte_next = cmd.send ? tx_b : 8'h00;
            olast_next = cmd.send && sts.last_byte;
            oev_next   = cmd.report ? res_ev_reg : co2seq_pkg::EV_NONE;
            oacc_next  = cmd.request && acc;
            ochg_next  = chg_reg;
            osen_next  = sen_reg;
            ouart_next = uart_reg;
            oerr_next  = err_reg;
            oconc_next = conc_reg;
            oval_next  = valid_reg;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tlast  = olast_reg;
    assign m_tuser  = okind_reg;
    assign m_tdata  = {5'd0, oacc_reg, oval_reg, oconc_reg, oerr_reg, oev_reg,
                       ouart_reg, osen_reg, ochg_reg, obyte_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressure_reg  <= co2seq_pkg::PRESSURE_RST;
            period_reg    <= '0;
            cal_per_reg   <= co2seq_pkg::CALIB_PER_RST;
            abc_reg       <= co2seq_pkg::ABC_RST;
            abc_rf_reg    <= co2seq_pkg::ABC_RF_RST;
            phase_reg     <= co2seq_pkg::PH_INIT;
            now_reg       <= '0;
            wake_reg      <= '0;
            tmo_reg       <= '0;
            cal_due_reg   <= co2seq_pkg::CALIB_PER_RST;
            intv_reg      <= '0;
            mode_reg      <= co2seq_pkg::ABC_RST;
            cal_run_reg   <= 1'b0;
            first_reg     <= 1'b0;
            cnt_reg       <= '0;
            sent_reg      <= '0;
            err_reg       <= co2seq_pkg::ERR_NONE;
            conc_reg      <= '0;
            valid_reg     <= 1'b0;
            chg_reg       <= 1'b0;
            sen_reg       <= 1'b0;
            uart_reg      <= 1'b0;
            frame_reg     <= co2seq_pkg::FR_INIT;
            idx_reg       <= '0;
            res_ev_reg    <= co2seq_pkg::EV_NONE;
            res_frame_reg <= 1'b0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            pressure_reg  <= pressure_next;
            period_reg    <= period_next;
            cal_per_reg   <= cal_per_next;
            abc_reg       <= abc_next;
            abc_rf_reg    <= abc_rf_next;
            phase_reg     <= phase_next;
            now_reg       <= now_next;
            wake_reg      <= wake_next;
            tmo_reg       <= tmo_next;
            cal_due_reg   <= cal_due_next;
            intv_reg      <= intv_next;
            mode_reg      <= mode_next;
            cal_run_reg   <= cal_run_next;
            first_reg     <= first_next;
            cnt_reg       <= cnt_next;
            sent_reg      <= sent_next;
            err_reg       <= err_next;
            conc_reg      <= conc_next;
            valid_reg     <= valid_next;
            chg_reg       <= chg_next;
            sen_reg       <= sen_next;
            uart_reg      <= uart_next;
            frame_reg     <= frame_next;
            idx_reg       <= idx_next;
            res_ev_reg    <= res_ev_next;
            res_frame_reg <= res_frame_next;
            ov_reg        <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rx_crc_reg  <= rx_crc_next;
        b0_reg      <= b0_next;
        b1_reg      <= b1_next;
        st0_reg     <= st0_next;
        st1_reg     <= st1_next;
        chi_reg     <= chi_next;
        clo_reg     <= clo_next;
        pend_reg    <= pend_next;
        saved_reg   <= saved_next;
        rdy_in_reg  <= rdy_in_next;
        mode_in_reg <= mode_in_next;
        kind_in_reg <= kind_in_next;
        tx_crc_reg  <= tx_crc_next;
        okind_reg   <= okind_next;
        obyte_reg   <= obyte_next;
        olast_reg   <= olast_next;
        oev_reg     <= oev_next;
        oacc_reg    <= oacc_next;
        ochg_reg    <= ochg_next;
        osen_reg    <= osen_next;
        ouart_reg   <= ouart_next;
        oerr_reg    <= oerr_next;
        oconc_reg   <= oconc_next;
        oval_reg    <= oval_next;
    end

endmodule

/* design/co2_sensor_modbus_sequencer.sv */
`timescale 1ns / 1ps
// Pulsed CO2 sensor sequencer on a Modbus-style UART link. Input items (s_tuser:
// tick, received byte, measure request, calibration request) are taken one at a
// time. A received byte is captured while a reply is read. A tick advances the time,
// serves the measure interval and, when a step is due, runs it and then sends its
// frame or reports its result. A request waits for the output register. A step that
// sends a frame emits 7, 8 or SENSOR_STATE_BYTES + 10 transmit bytes, one per
// cycle while the output accepts them, with the CRC computed byte by byte by the
// datapath as the frame streams out. Configuration writes are taken in any cycle
// (cfg_ready is always high) and must only be issued while the block is idle.
module co2_sensor_modbus_sequencer
#(
    parameter int REPLY_BYTES        = co2seq_pkg::REPLY_BYTES_DEF,
    parameter int SENSOR_STATE_BYTES = co2seq_pkg::SENSOR_STATE_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // rx_byte[7:0], ready_level[8], calib_mode[16:9], zeros
    input  logic [1:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    // tx_byte[7:0], charge_on[8], sensor_on[9], uart_on[10], event_res[12:11],
    // error_code[16:13], concentration[32:17], valid_res[33], accepted[34], zeros
    output logic [39:0] m_tdata,
    output logic        m_tlast,
    output logic        m_tuser,   // out_kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    co2seq_pkg::cmd_t    cmd;
    co2seq_pkg::status_t sts;

    assign cfg_ready = 1'b1;

    co2seq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    co2seq_dp
    #(
        .REPLY_BYTES        (REPLY_BYTES),
        .SENSOR_STATE_BYTES (SENSOR_STATE_BYTES)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_kind   (s_tuser),
        .in_byte   (s_tdata[7:0]),
        .in_ready  (s_tdata[8]),
        .in_mode   (s_tdata[16:9]),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.send || cmd.report || cmd.request) |-> sts.out_free)
        else $error("result loaded while output register full");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.send, cmd.report, cmd.request, cmd.run}))
        else $error("conflicting commands");

    a_last_tx: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> !m_tuser)
        else $error("frame end marked on a report");
`endif

endmodule
